// ----- src/cable_robot_xy_to_motor_frame_macros.svh -----
// Assertion macros for the cable robot frame block
`ifndef CABLE_ROBOT_XY_TO_MOTOR_FRAME_MACROS_SVH
`define CABLE_ROBOT_XY_TO_MOTOR_FRAME_MACROS_SVH
// Assert that a property holds at every clock edge outside reset
`define CR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle
`define CR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/crxy_pkg.sv -----
// Shared types and constants for the cable robot frame block
package crxy_pkg;
  localparam int COEF_FRAC_BITS = 12;
  localparam int FRAME_LEN = 61;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        clamped;
  } point_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] current;
  } words_t;
endpackage

// ----- src/cable_robot_xy_to_motor_frame.sv -----
// Top level of the cable robot frame block
// Each target point is taken from the point queue, then goes through four square roots
// (load, 14 steps and finish, each root followed by a multiply) and then the 61 frame
// bytes are sent, each one held while the output stalls. The next point starts only
// after the last byte has gone out; a two-entry point queue lets new points arrive
// meanwhile.
module cable_robot_xy_to_motor_frame (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // target_x[12:0], target_y[25:13]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // frame_byte[7:0]
  output logic        m_tlast,
  output logic        m_tuser   // was_clamped[0]
);
  logic [11:0] side;
  logic [15:0] c [4];
  crxy_pkg::words_t words;
  logic             qv;
  logic             qr;
  crxy_pkg::point_t qd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= 12'd1500;
      c[0] <= 16'hBB33;
      c[1] <= 16'd17613;
      c[2] <= 16'hBB33;
      c[3] <= 16'd17613;
      words.speed <= 16'd20000;
      words.current <= 16'd2000;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        3'd0: side <= pwdata[11:0];
        3'd1: c[0] <= pwdata[15:0];
        3'd2: c[1] <= pwdata[15:0];
        3'd3: c[2] <= pwdata[15:0];
        3'd4: c[3] <= pwdata[15:0];
        3'd5: words.speed <= pwdata[15:0];
        3'd6: words.current <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      3'd0: prdata = {20'd0, side};
      3'd1: prdata = {16'd0, c[0]};
      3'd2: prdata = {16'd0, c[1]};
      3'd3: prdata = {16'd0, c[2]};
      3'd4: prdata = {16'd0, c[3]};
      3'd5: prdata = {16'd0, words.speed};
      3'd6: prdata = {16'd0, words.current};
      default: prdata = '0;
    endcase
  end

  crxy_front u_front (
    .clk(clk), .rst(rst), .side(side),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .q_valid(qv), .q_ready(qr), .q_data(qd)
  );

  crxy_back u_back (
    .clk(clk), .rst(rst), .side(side),
    .coefs({c[3], c[2], c[1], c[0]}), .words(words),
    .q_valid(qv), .q_ready(qr), .q_data(qd),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );
endmodule

// ----- src/crxy_front.sv -----
// Front: accept a target point, clamp it, and push it into the queue
module crxy_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [11:0]          side,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,
  output logic                 q_valid,
  input  logic                 q_ready,
  output crxy_pkg::point_t     q_data
);
  crxy_pkg::point_t mem [crxy_pkg::QDEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic signed [12:0] tx;
  logic signed [12:0] ty;
  logic signed [13:0] sd;
  crxy_pkg::point_t   pt;
  logic               push;
  logic               pop;

  assign tx = s_tdata[12:0];
  assign ty = s_tdata[25:13];
  assign sd = {2'b00, side};

  always_comb begin
    pt.clamped = 1'b0;
    if (tx < 0) begin
      pt.x = '0;
      pt.clamped = 1'b1;
    end else if ({tx[12], tx} > sd) begin
      pt.x = side;
      pt.clamped = 1'b1;
    end else begin
      pt.x = tx[11:0];
    end
    if (ty < 0) begin
      pt.y = '0;
      pt.clamped = 1'b1;
    end else if ({ty[12], ty} > sd) begin
      pt.y = side;
      pt.clamped = 1'b1;
    end else begin
      pt.y = ty[11:0];
    end
  end

  assign s_tready = (count != 2'(crxy_pkg::QDEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= pt;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- src/crxy_back.sv -----
// Back: compute cable lengths and angles, then stream the frame bytes
module crxy_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [11:0]         side,
  input  logic [63:0]         coefs,
  input  crxy_pkg::words_t    words,
  input  logic                q_valid,
  output logic                q_ready,
  input  crxy_pkg::point_t    q_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);
  typedef enum logic [1:0] {IDLE, SQRT, MUL, EMIT} state_t;
  state_t      state;
  crxy_pkg::point_t cur;
  logic [1:0]  motor;
  logic [3:0]  step;
  logic [31:0] rem;
  logic [31:0] res;
  logic [31:0] bitv;
  logic [31:0] pos [4];
  logic        dir [4];
  logic [15:0] len;
  logic [5:0]  idx;
  logic signed [12:0] dx;
  logic signed [12:0] dy;
  logic [25:0] sqv;
  logic signed [15:0] cf;
  logic signed [32:0] prod;
  logic [32:0] mag;
  logic [32:0] rnd;
  logic [5:0]  off;
  logic [1:0]  cm;
  logic [3:0]  fi;
  logic [7:0]  byte_v;

  always_comb begin
    case (motor)
      2'd0: begin dx = {1'b0, cur.x}; dy = {1'b0, cur.y}; end
      2'd1: begin dx = {1'b0, cur.x}; dy = {1'b0, cur.y} - {1'b0, side}; end
      2'd2: begin
        dx = {1'b0, cur.x} - {1'b0, side};
        dy = {1'b0, cur.y} - {1'b0, side};
      end
      default: begin dx = {1'b0, cur.x} - {1'b0, side}; dy = {1'b0, cur.y}; end
    endcase
    sqv = 26'(dx * dx) + 26'(dy * dy);
    cf = coefs[16*motor +: 16];
    prod = $signed({1'b0, len}) * cf;
    mag = prod[32] ? 33'(-prod) : prod;
    rnd = (mag + (33'd1 << (crxy_pkg::COEF_FRAC_BITS - 1))) >> crxy_pkg::COEF_FRAC_BITS;
  end

  always_comb begin
    off = '0;
    cm = '0;
    fi = '0;
    byte_v = 8'h6B;
    if (idx < 6'd4) begin
      case (idx[1:0])
        2'd1: byte_v = 8'hAA;
        2'd3: byte_v = 8'h3B;
        default: byte_v = 8'h00;
      endcase
    end else if (idx < 6'd60) begin
      off = idx - 6'd4;
      if (off < 6'd14) cm = 2'd0;
      else if (off < 6'd28) cm = 2'd1;
      else if (off < 6'd42) cm = 2'd2;
      else cm = 2'd3;
      fi = 4'(off - 6'(cm) * 6'd14);
      case (fi)
        4'd0: byte_v = {6'd0, cm} + 8'd1;
        4'd1: byte_v = 8'hCB;
        4'd2: byte_v = {7'd0, dir[cm]};
        4'd3: byte_v = words.speed[15:8];
        4'd4: byte_v = words.speed[7:0];
        4'd5: byte_v = pos[cm][31:24];
        4'd6: byte_v = pos[cm][23:16];
        4'd7: byte_v = pos[cm][15:8];
        4'd8: byte_v = pos[cm][7:0];
        4'd9: byte_v = 8'h01;
        4'd10: byte_v = 8'h00;
        4'd11: byte_v = words.current[15:8];
        4'd12: byte_v = words.current[7:0];
        default: byte_v = 8'h6B;
      endcase
    end
  end

  assign q_ready = (state == IDLE);
  assign m_tvalid = (state == EMIT);
  assign m_tdata = byte_v;
  assign m_tlast = (idx == 6'(crxy_pkg::FRAME_LEN - 1));
  assign m_tuser = cur.clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx <= '0;
    end else begin
      case (state)
        IDLE: if (q_valid) begin
          cur <= q_data;
          motor <= '0;
          state <= SQRT;
          step <= '0;
        end
        SQRT: begin
          if (step == 4'd0) begin
            rem <= {6'd0, sqv};
            res <= '0;
            bitv <= 32'h1 << 26;
            step <= 4'd1;
          end else if (bitv == 32'd0) begin
            len <= res[15:0];
            state <= MUL;
          end else begin
            if (rem >= res + bitv) begin
              rem <= rem - (res + bitv);
              res <= (res >> 1) + bitv;
            end else begin
              res <= res >> 1;
            end
            bitv <= bitv >> 2;
          end
        end
        MUL: begin
          pos[motor] <= rnd[31:0];
          dir[motor] <= prod[32];
          step <= '0;
          if (motor == 2'd3) begin
            state <= EMIT;
            idx <= '0;
          end else begin
            motor <= motor + 2'd1;
            state <= SQRT;
          end
        end
        EMIT: if (m_tready) begin
          if (m_tlast) begin
            state <= IDLE;
            idx <= '0;
          end else begin
            idx <= idx + 6'd1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`include "cable_robot_xy_to_motor_frame_macros.svh"
  `CR_ASSERT(a_idx_range, idx < 6'(crxy_pkg::FRAME_LEN), "byte index past frame")
  `CR_ASSERT(a_ready_idle, !(q_ready && m_tvalid), "accepting while emitting")
  `CR_ASSERT_NEXT(a_last_end, m_tvalid && m_tready && m_tlast, state == IDLE, "no idle after last")
endmodule
